/* rtl/rsba_pkg.sv */
// ----------------------------------------------------------------------------
// rsba_pkg
// Types and constants shared by the random slot bitmap allocator.
// ----------------------------------------------------------------------------
package rsba_pkg;

	localparam int NUM_SLOTS_DEF = 32;

	localparam int CMD_W   = 2;
	localparam int IDX_W_IO = 6;
	localparam int RND_W   = 16;
	localparam int WORD_W  = 16;
	localparam int CNT_W_IO = 7;

	localparam logic [CMD_W-1:0] CMD_MARK      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DRAW_FREE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DRAW_USED = 2'd2;

	localparam logic [WORD_W-1:0] WORD_BASE = 16'h2800;
	localparam logic [WORD_W-1:0] WORD_NONE = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

/* rtl/rsba_req_if.sv */
// ----------------------------------------------------------------------------
// rsba_req_if
// Request channel: command, slot index and random value.
// ----------------------------------------------------------------------------
interface rsba_req_if;
	import rsba_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [IDX_W_IO-1:0] slot_index;
	logic [RND_W-1:0]    random_value;

	modport source (output valid, command, slot_index, random_value, input ready);
	modport sink   (input valid, command, slot_index, random_value, output ready);
endinterface

/* rtl/rsba_rsp_if.sv */
// ----------------------------------------------------------------------------
// rsba_rsp_if
// Response channel: word code, tested slot bit and set slot count.
// ----------------------------------------------------------------------------
interface rsba_rsp_if;
	import rsba_pkg::*;

	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   word_code;
	logic                slot_was_set;
	logic [CNT_W_IO-1:0] set_count;

	modport source (output valid, word_code, slot_was_set, set_count, input ready);
	modport sink   (input valid, word_code, slot_was_set, set_count, output ready);
endinterface

/* rtl/random_slot_bitmap_allocator_top.sv */
// ----------------------------------------------------------------------------
// random_slot_bitmap_allocator_top
// Slot bitmap with mark, draw-free and draw-used commands; bit-serial
// remainder and one-slot-per-cycle scan.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields
// req      in   command, slot_index, random_value
// rsp      out  word_code, slot_was_set, set_count
//
// Mark and unused commands go from accept to ST_DONE, which posts their
// response once rsp is free. Draws run the bit-serial remainder in ST_DIV and
// the scan in ST_SCAN; a pool with no slot to draw skips remainder and scan.
// One transaction in flight; req is taken while a response waits on rsp.
// Reset clears the bitmap and count at once, no clearing pass.
// ----------------------------------------------------------------------------
module random_slot_bitmap_allocator_top #(
	parameter int NUM_SLOTS = rsba_pkg::NUM_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rsba_req_if.sink   req,
	rsba_rsp_if.source rsp
);
	import rsba_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int BIT_W = $clog2(RND_W);
	localparam logic [CNT_W-1:0] NUM_C = CNT_W'(NUM_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	state_t state_q, state_d;

	logic [NUM_SLOTS-1:0] slot_map_q;
	logic [NUM_SLOTS-1:0] scan_map_q;
	logic [CNT_W-1:0]     used_q;
	logic [CMD_W-1:0]     cmd_q;
	logic                 was_set_q;
	logic [RND_W-1:0]     dvd_q;
	logic [CNT_W-1:0]     div_q;
	logic [CNT_W-1:0]     rem_q;
	logic [BIT_W-1:0]     bit_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [IDX_W-1:0]     pos_q;
	logic                 hit_q;

	logic                 out_valid_q;
	logic [WORD_W-1:0]    word_q;
	logic                 out_was_q;
	logic [CNT_W_IO-1:0]  out_cnt_q;

	logic                 acc;
	logic                 idx_ok;
	logic                 cur_bit;
	logic [CNT_W-1:0]     free_n;
	logic [CNT_W-1:0]     divisor;
	logic [CNT_W:0]       trial;
	logic                 ge;
	logic                 want;
	logic                 match;
	logic                 found;
	logic                 emit;

	assign acc     = req.valid && req.ready;
	assign idx_ok  = {1'b0, req.slot_index} < (IDX_W_IO + 1)'(NUM_SLOTS);
	assign cur_bit = idx_ok ? slot_map_q[req.slot_index[IDX_W-1:0]] : 1'b0;
	assign free_n  = NUM_C - used_q;
	assign divisor = (req.command == CMD_DRAW_FREE) ? free_n : used_q;
	assign trial   = {rem_q, dvd_q[RND_W-1]};
	assign ge      = trial >= {1'b0, div_q};
	assign want    = (cmd_q == CMD_DRAW_USED);
	assign match   = (scan_map_q[0] == want);
	assign found   = match && (rem_q == '0);
	assign emit    = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if ((req.command == CMD_DRAW_FREE || req.command == CMD_DRAW_USED)
						&& divisor != '0) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV: begin
				if (bit_q == BIT_W'(RND_W - 1)) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (found) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_map_q  <= '0;
			used_q      <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					hit_q <= 1'b0;
					if (acc && req.command == CMD_MARK && idx_ok && !cur_bit) begin
						slot_map_q[req.slot_index[IDX_W-1:0]] <= 1'b1;
						used_q <= used_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (found) begin
						hit_q <= 1'b1;
						if (cmd_q == CMD_DRAW_FREE) begin
							slot_map_q[ptr_q] <= 1'b1;
							used_q <= used_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					cmd_q     <= req.command;
					was_set_q <= cur_bit;
					dvd_q     <= req.random_value;
					div_q     <= divisor;
					rem_q     <= '0;
					bit_q     <= '0;
				end
			end
			ST_DIV: begin
				rem_q      <= ge ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
				dvd_q      <= {dvd_q[RND_W-2:0], 1'b0};
				bit_q      <= bit_q + 1'b1;
				scan_map_q <= slot_map_q;
				ptr_q      <= '0;
			end
			ST_SCAN: begin
				if (found) begin
					pos_q <= ptr_q;
				end else begin
					if (match) rem_q <= rem_q - 1'b1;
					scan_map_q <= scan_map_q >> 1;
					ptr_q      <= ptr_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (emit) begin
					word_q    <= hit_q ? (WORD_BASE | WORD_W'(pos_q)) : WORD_NONE;
					out_was_q <= was_set_q;
					out_cnt_q <= CNT_W_IO'(used_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.word_code    = word_q;
	assign rsp.slot_was_set = out_was_q;
	assign rsp.set_count    = out_cnt_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		used_q == CNT_W'($countones(slot_map_q)))
		else $error("set count differs from bitmap");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= NUM_C)
		else $error("set count above slot count");

	a_scan_finds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && ptr_q == LAST_IDX) |-> found)
		else $error("scan ran past last slot");

	a_idle_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (rsp.valid && state_q == ST_IDLE))
		else $error("response not posted after done");

endmodule

/* verif/random_slot_bitmap_allocator_top_tb.sv */
// ----------------------------------------------------------------------------
// random_slot_bitmap_allocator_top_tb
// Self-checking bench for the slot bitmap allocator: a scoreboard tracks its
// own copy of the bitmap, predicts word code, prior slot bit and set count
// for every accepted request, and checks each response in order. Directed
// corner requests first, then random traffic that fills the pool slowly so
// every occupancy level sees draws, with idle gaps and backpressure on both
// channels, including one long response hold-off.
// ----------------------------------------------------------------------------
module random_slot_bitmap_allocator_top_tb;
	import rsba_pkg::*;

	localparam int SLOTS = NUM_SLOTS_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1250;

	typedef struct packed {
		logic [WORD_W-1:0]   word;
		logic                was_set;
		logic [CNT_W_IO-1:0] count;
	} slot_result_t;

	class slot_map_scoreboard;
		bit [SLOTS-1:0] slots;
		slot_result_t   due_results[$];
		int             errors;
		int             cmd_seen[4];
		int             none_draws;

		function new();
			slots = '0;
			errors = 0;
			none_draws = 0;
			foreach (cmd_seen[i]) cmd_seen[i] = 0;
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		function int kth_slot(bit want, int k);
			for (int i = 0; i < SLOTS; i++) begin
				if (slots[i] == want) begin
					if (k == 0) return i;
					k--;
				end
			end
			return SLOTS;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [IDX_W_IO-1:0] idx,
				logic [RND_W-1:0] rnd);
			slot_result_t r;
			int used;
			int pos;
			r.word = WORD_NONE;
			r.was_set = (int'(idx) < SLOTS) ? slots[idx] : 1'b0;
			used = $countones(slots);
			cmd_seen[cmd]++;
			case (cmd)
				CMD_MARK: begin
					if (int'(idx) < SLOTS) slots[idx] = 1'b1;
				end
				CMD_DRAW_FREE: begin
					if (used < SLOTS) begin
						pos = kth_slot(1'b0, int'(rnd) % (SLOTS - used));
						slots[pos] = 1'b1;
						r.word = WORD_BASE | WORD_W'(pos);
					end else begin
						none_draws++;
					end
				end
				CMD_DRAW_USED: begin
					if (used != 0) begin
						pos = kth_slot(1'b1, int'(rnd) % used);
						r.word = WORD_BASE | WORD_W'(pos);
					end else begin
						none_draws++;
					end
				end
				default: ;
			endcase
			r.count = CNT_W_IO'($countones(slots));
			due_results.push_back(r);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40) $display("%0t MISMATCH: %s", $realtime, what);
		endtask

		task check_response(logic [WORD_W-1:0] word, logic was_set,
				logic [CNT_W_IO-1:0] count);
			slot_result_t e;
			if (due_results.size() == 0) begin
				report_mismatch("response with no transaction outstanding");
				return;
			end
			e = due_results.pop_front();
			if (word !== e.word)
				report_mismatch($sformatf("word_code %h, expected %h", word, e.word));
			if (was_set !== e.was_set)
				report_mismatch($sformatf("slot_was_set %b, expected %b", was_set, e.was_set));
			if (count !== e.count)
				report_mismatch($sformatf("set_count %0d, expected %0d", count, e.count));
		endtask
	endclass

	logic clk;
	logic arst_n;

	rsba_req_if req_ch ();
	rsba_rsp_if rsp_ch ();

	random_slot_bitmap_allocator_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	slot_map_scoreboard sb = new();

	bit src_calm;
	int rsp_seen;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W_IO-1:0] idx,
			input logic [RND_W-1:0] rnd);
		int gap;
		if (!src_calm && $urandom_range(0, 99) < 26) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 60) : $urandom_range(1, 3);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= cmd;
		req_ch.slot_index   <= idx;
		req_ch.random_value <= rnd;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(cmd, idx, rnd);
	endtask

	// response side: random backpressure, a calm window and one long hold-off
	initial begin
		rsp_seen = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				sb.check_response(rsp_ch.word_code, rsp_ch.slot_was_set, rsp_ch.set_count);
				rsp_seen++;
				if (rsp_seen == 300) hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!(rsp_seen >= 900 && rsp_seen < 1150)
					&& $urandom_range(0, 99) < 26) begin
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [CMD_W-1:0]    c;
		logic [IDX_W_IO-1:0] ix;
		logic [RND_W-1:0]    r;
		int                  fill_pct;
		int                  pick;
		src_calm = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.command      <= CMD_MARK;
		req_ch.slot_index   <= '0;
		req_ch.random_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool, ignored indices, unused command, extremes of the random value
		send_request(CMD_DRAW_USED, 6'd0,  16'h0000);
		send_request(CMD_DRAW_USED, 6'd63, 16'hFFFF);
		send_request(CMD_UNUSED,    6'd5,  RND_W'($urandom));
		send_request(CMD_MARK,      6'd32, 16'h0000);
		send_request(CMD_MARK,      6'd63, 16'hFFFF);
		send_request(CMD_MARK,      6'd0,  16'h0000);
		send_request(CMD_MARK,      6'd0,  16'h1234);
		send_request(CMD_MARK,      6'd31, 16'h0000);
		send_request(CMD_DRAW_USED, 6'd31, 16'h0000);
		send_request(CMD_DRAW_USED, 6'd0,  16'hFFFF);
		send_request(CMD_DRAW_FREE, 6'd1,  16'h0000);
		send_request(CMD_DRAW_FREE, 6'd1,  16'hFFFF);
		send_request(CMD_DRAW_FREE, 6'd1,  16'h8000);
		send_request(CMD_UNUSED,    6'd63, 16'hFFFF);
		send_request(CMD_DRAW_USED, 6'd40, 16'h5555);
		send_request(CMD_MARK,      6'd42, 16'hAAAA);
		send_request(CMD_MARK,      6'd21, 16'h5555);

		// pool fills slowly, then fast so the full case is exercised at the end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			src_calm = (i >= 500 && i < 750);
			fill_pct = (i < 1000) ? 3 : 45;
			r = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
				: RND_W'($urandom_range(0, 65535));
			ix = IDX_W_IO'($urandom_range(0, 63));
			pick = $urandom_range(0, 99);
			if (pick < fill_pct) begin
				if ($urandom_range(0, 1)) begin
					c = CMD_MARK;
					ix = IDX_W_IO'($urandom_range(0, SLOTS - 1));
				end else begin
					c = CMD_DRAW_FREE;
				end
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					c = CMD_DRAW_USED;
				end else if (pick < 90) begin
					c = CMD_MARK;
					ix = IDX_W_IO'($urandom_range(SLOTS, 63));
				end else begin
					c = CMD_UNUSED;
				end
			end
			send_request(c, ix, r);
		end
		src_calm = 1'b0;
		req_ch.valid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Covered %0d marks, %0d draw-free, %0d draw-used and %0d unused commands;",
			sb.cmd_seen[CMD_MARK], sb.cmd_seen[CMD_DRAW_FREE], sb.cmd_seen[CMD_DRAW_USED],
			sb.cmd_seen[CMD_UNUSED]);
		$display("%0d draws hit an empty or full pool, final set count %0d, %0d mismatches.",
			sb.none_draws, $countones(sb.slots), sb.errors);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

/* sim.f */
rtl/rsba_pkg.sv
rtl/rsba_req_if.sv
rtl/rsba_rsp_if.sv
rtl/random_slot_bitmap_allocator_top.sv
verif/random_slot_bitmap_allocator_top_tb.sv
